// ===== hw/rtl/itsp_pkg.sv =====
package itsp_pkg;

  // Default sizing of the pool
  localparam int CapacityDef  = 64;
  localparam int IdBitsDef    = 32;
  localparam int WordBitsDef  = 32;

  // Fixed field widths on the channels
  localparam int CmdW    = 2;
  localparam int StatusW = 2;
  localparam int IndexW  = 7;
  localparam int FieldW  = 32;
  localparam int WideW   = 64;

  typedef enum logic [CmdW-1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_ITER  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_END       = 2'd3
  } status_t;

  // What every cell of the row does in a cycle
  typedef enum logic [1:0] {
    CELL_HOLD  = 2'd0,
    CELL_SHIFT = 2'd1,
    CELL_LOAD  = 2'd2
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     fill_live;
  } cell_ctrl_t;

endpackage

// ===== hw/rtl/itsp_ifs.sv =====
interface itsp_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [31:0] target_id;
  logic [6:0]  from_index;
  logic        from_start;
  logic [31:0] write_word;

  modport source (output valid, cmd, target_id, from_index, from_start, write_word,
                  input ready);
  modport sink (input valid, cmd, target_id, from_index, from_start, write_word,
                output ready);
endinterface

interface itsp_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [6:0]  slot_index;
  logic [31:0] slot_id;
  logic [31:0] read_word;

  modport source (output valid, status, slot_index, slot_id, read_word, input ready);
  modport sink (input valid, status, slot_index, slot_id, read_word, output ready);
endinterface

// ===== hw/rtl/itsp_cell.sv =====
module itsp_cell #(
  parameter int IDX       = 0,
  parameter int IDX_W     = 6,
  parameter int ID_BITS   = 32,
  parameter int WORD_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  itsp_pkg::cell_ctrl_t ctrl,
  input  logic [IDX_W-1:0]     bnd,
  input  logic [ID_BITS-1:0]   next_tag,
  input  logic [WORD_BITS-1:0] next_word,
  input  logic                 next_live,
  input  logic [ID_BITS-1:0]   fill_tag,
  input  logic [WORD_BITS-1:0] fill_word,
  output logic [ID_BITS-1:0]   tag,
  output logic [WORD_BITS-1:0] word,
  output logic                 live
);
  import itsp_pkg::*;

  localparam logic [IDX_W-1:0] MyIdx = IDX_W'(IDX);

  logic take_next;
  logic take_fill;

  // Below the boundary take the neighbor on a shift; at the boundary take the fill beat
  always_comb begin
    take_next = 1'b0;
    take_fill = 1'b0;
    unique case (ctrl.op)
      CELL_HOLD: begin
      end
      CELL_SHIFT: begin
        take_next = (MyIdx < bnd);
        take_fill = (MyIdx == bnd);
      end
      CELL_LOAD: begin
        take_fill = (MyIdx == bnd);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      live <= 1'b0;
    end else if (take_next) begin
      live <= next_live;
    end else if (take_fill) begin
      live <= ctrl.fill_live;
    end
  end

  always_ff @(posedge clk) begin
    if (take_next) begin
      tag  <= next_tag;
      word <= next_word;
    end else if (take_fill) begin
      tag  <= fill_tag;
      word <= fill_word;
    end
  end

endmodule

// ===== hw/rtl/id_tagged_slot_pool.sv =====
// Channel  Dir  Beat fields
// req      in   cmd, target_id, from_index, from_start, write_word
// rsp      out  status, slot_index, slot_id, read_word
//
// Allocate and unknown commands go straight to the result; iterate and free
// walk the row once, and a free that compacts adds a pack and an align walk:
// every walk rotates the row of slot cells one place per cycle past cell 0.
// rst is synchronous; it clears live marks and counters, slot data is kept.
// req is taken only between commands; a stalled rsp holds the next result
// back, but the next command is taken while a result waits.
module id_tagged_slot_pool #(
  parameter int CAPACITY  = itsp_pkg::CapacityDef,
  parameter int ID_BITS   = itsp_pkg::IdBitsDef,
  parameter int WORD_BITS = itsp_pkg::WordBitsDef
) (
  input logic        clk,
  input logic        rst,
  itsp_req_if.sink   req,
  itsp_rsp_if.source rsp
);
  import itsp_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = ((CNT_W > IndexW) ? CNT_W : IndexW) + 1;
  localparam logic [IDX_W-1:0] LastIdx = IDX_W'(CAPACITY - 1);
  localparam logic [CNT_W-1:0] CapCnt  = CNT_W'(CAPACITY);
  localparam logic [WideW-1:0] CapWide = WideW'(CAPACITY);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_FREE  = 6'b000010,
    S_ITER  = 6'b000100,
    S_PACK  = 6'b001000,
    S_ALIGN = 6'b010000,
    S_EMIT  = 6'b100000
  } state_t;

  state_t state;
  logic [IDX_W-1:0] r;
  logic [IDX_W-1:0] j;
  logic [CNT_W-1:0] used;
  logic [CNT_W-1:0] dead;
  logic [ID_BITS-1:0] idc;
  logic found;
  logic [ID_BITS-1:0] want;
  logic [CMP_W-1:0] start;

  logic [StatusW-1:0] res_status;
  logic [IndexW-1:0]  res_idx;
  logic [FieldW-1:0]  res_id;
  logic [FieldW-1:0]  res_word;

  logic               out_valid;
  logic [StatusW-1:0] out_status;
  logic [IndexW-1:0]  out_idx;
  logic [FieldW-1:0]  out_id;
  logic [FieldW-1:0]  out_word;

  // Row of slot cells
  logic [ID_BITS-1:0]   cell_tag  [CAPACITY];
  logic [WORD_BITS-1:0] cell_word [CAPACITY];
  logic                 cell_live [CAPACITY];

  cell_ctrl_t           ctrl;
  logic [IDX_W-1:0]     bnd;
  logic [ID_BITS-1:0]   fill_tag;
  logic [WORD_BITS-1:0] fill_word;

  logic accept;
  logic r_last;
  logic r_used;
  logic free_hit;
  logic iter_hit;
  logic keep;
  logic [IDX_W-1:0] j_end;
  logic [CNT_W-1:0] dead_inc;

  logic [WideW-1:0] req_id_w;
  logic [WideW-1:0] req_word_w;
  logic [WideW-1:0] idc_w;
  logic [WideW-1:0] head_tag_w;
  logic [WideW-1:0] head_word_w;
  logic [WideW-1:0] r_w;
  logic [WideW-1:0] used_w;
  logic [CMP_W-1:0] start_calc;

  assign accept    = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);

  assign rsp.valid      = out_valid;
  assign rsp.status     = out_status;
  assign rsp.slot_index = out_idx;
  assign rsp.slot_id    = out_id;
  assign rsp.read_word  = out_word;

  // Widen and narrow fields between port and pool widths
  always_comb begin
    req_id_w                     = '0;
    req_id_w[FieldW-1:0]         = req.target_id;
    req_word_w                   = '0;
    req_word_w[FieldW-1:0]       = req.write_word;
    idc_w                        = '0;
    idc_w[ID_BITS-1:0]           = idc;
    head_tag_w                   = '0;
    head_tag_w[ID_BITS-1:0]      = cell_tag[0];
    head_word_w                  = '0;
    head_word_w[WORD_BITS-1:0]   = cell_word[0];
    r_w                          = '0;
    r_w[IDX_W-1:0]               = r;
    used_w                       = '0;
    used_w[CNT_W-1:0]            = used;
    start_calc = CMP_W'(req.from_index) + CMP_W'(!req.from_start);
  end

  assign r_last   = (r == LastIdx);
  assign r_used   = (CNT_W'(r) < used);
  assign free_hit = !found && r_used && (cell_tag[0] == want);
  assign iter_hit = !found && r_used && cell_live[0] && (CMP_W'(r) >= start);
  assign keep     = r_used && cell_live[0];
  assign j_end    = keep ? j + 1'b1 : j;
  assign dead_inc = dead + 1'b1;

  // Drive the row: rotate through cell 0, drop at the kept boundary, or load
  always_comb begin
    ctrl.op        = CELL_HOLD;
    ctrl.fill_live = cell_live[0];
    bnd            = LastIdx;
    fill_tag       = cell_tag[0];
    fill_word      = cell_word[0];
    unique case (state)
      S_IDLE: begin
        if (accept && (cmd_t'(req.cmd) == CMD_ALLOC) && (used < CapCnt)) begin
          ctrl.op        = CELL_LOAD;
          ctrl.fill_live = 1'b1;
          bnd            = used[IDX_W-1:0];
          fill_tag       = idc;
          fill_word      = req_word_w[WORD_BITS-1:0];
        end
      end
      S_FREE: begin
        ctrl.op        = CELL_SHIFT;
        ctrl.fill_live = cell_live[0] && !free_hit;
      end
      S_ITER, S_ALIGN: begin
        ctrl.op = CELL_SHIFT;
      end
      S_PACK: begin
        ctrl.op = CELL_SHIFT;
        if (!keep) begin
          ctrl.fill_live = 1'b0;
          bnd            = LastIdx - j;
        end
      end
      S_EMIT: begin
      end
      default: begin
      end
    endcase
  end

  for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
    localparam int Nxt = (gi + 1 < CAPACITY) ? gi + 1 : gi;
    itsp_cell #(
      .IDX       (gi),
      .IDX_W     (IDX_W),
      .ID_BITS   (ID_BITS),
      .WORD_BITS (WORD_BITS)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .bnd       (bnd),
      .next_tag  (cell_tag[Nxt]),
      .next_word (cell_word[Nxt]),
      .next_live (cell_live[Nxt]),
      .fill_tag  (fill_tag),
      .fill_word (fill_word),
      .tag       (cell_tag[gi]),
      .word      (cell_word[gi]),
      .live      (cell_live[gi])
    );
  end

  // Sequence commands and walks
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      r     <= '0;
      j     <= '0;
      used  <= '0;
      dead  <= '0;
      idc   <= '0;
      found <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            r          <= '0;
            j          <= '0;
            found      <= 1'b0;
            want       <= req_id_w[ID_BITS-1:0];
            start      <= start_calc;
            res_status <= ST_END;
            res_idx    <= CapWide[IndexW-1:0];
            res_id     <= '0;
            res_word   <= '0;
            unique case (cmd_t'(req.cmd))
              CMD_ALLOC: begin
                state <= S_EMIT;
                if (used < CapCnt) begin
                  used       <= used + 1'b1;
                  idc        <= idc + 1'b1;
                  res_status <= ST_OK;
                  res_idx    <= used_w[IndexW-1:0];
                  res_id     <= idc_w[FieldW-1:0];
                end else begin
                  res_status <= ST_FULL;
                end
              end
              CMD_FREE: state <= S_FREE;
              CMD_ITER: state <= S_ITER;
              CMD_NONE: state <= S_EMIT;
              default:  state <= S_EMIT;
            endcase
          end
        end
        S_FREE: begin
          r <= r + 1'b1;
          if (free_hit) begin
            found <= 1'b1;
          end
          if (r_last) begin
            r     <= '0;
            state <= S_EMIT;
            if (found || free_hit) begin
              res_status <= ST_OK;
              dead       <= dead_inc;
              if (dead_inc >= (used >> 1)) begin
                state <= S_PACK;
              end
            end else begin
              res_status <= ST_NOT_FOUND;
            end
          end
        end
        S_ITER: begin
          r <= r + 1'b1;
          if (iter_hit) begin
            found      <= 1'b1;
            res_status <= ST_OK;
            res_idx    <= r_w[IndexW-1:0];
            res_id     <= head_tag_w[FieldW-1:0];
            res_word   <= head_word_w[FieldW-1:0];
          end
          if (r_last) begin
            state <= S_EMIT;
          end
        end
        S_PACK: begin
          r <= r + 1'b1;
          j <= j_end;
          if (r_last) begin
            used  <= CNT_W'(j_end);
            dead  <= '0;
            r     <= j_end;
            state <= S_ALIGN;
          end
        end
        S_ALIGN: begin
          r <= r + 1'b1;
          if (r_last) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!out_valid || rsp.ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Hold the result beat until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_EMIT) && (!out_valid || rsp.ready)) begin
      out_valid  <= 1'b1;
      out_status <= res_status;
      out_idx    <= res_idx;
      out_id     <= res_id;
      out_word   <= res_word;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  a_used_bound : assert property (@(posedge clk) disable iff (rst) used <= CapCnt)
    else $error("used slot count beyond capacity");

  a_dead_bound : assert property (@(posedge clk) disable iff (rst) dead <= used)
    else $error("dead count beyond used count");

  a_pack_clears : assert property (@(posedge clk) disable iff (rst)
      (state == S_ALIGN) |-> (dead == '0))
    else $error("dead count not cleared by compaction");

  a_pack_shrinks : assert property (@(posedge clk) disable iff (rst)
      (state == S_PACK) && r_last |=> used < $past(used))
    else $error("compaction did not drop a slot");

endmodule

// ===== dv/tb_pool_checker.sv =====
module tb_pool_checker
  import itsp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  input  logic       req_ready,
  input  logic [1:0] req_cmd,
  input  logic [31:0] req_target_id,
  input  logic [6:0] req_from_index,
  input  logic       req_from_start,
  input  logic [31:0] req_write_word,
  input  logic       rsp_valid,
  input  logic       rsp_ready,
  input  logic [1:0] rsp_status,
  input  logic [6:0] rsp_slot_index,
  input  logic [31:0] rsp_slot_id,
  input  logic [31:0] rsp_read_word,
  output int         fail_count,
  output int         pending_results,
  output int         used_now,
  output logic [31:0] next_id
);

  localparam int Cap = CapacityDef;

  typedef struct packed {
    status_t     status;
    logic [6:0]  slot_index;
    logic [31:0] slot_id;
    logic [31:0] read_word;
  } answer_t;

  logic [31:0] tags [Cap];
  logic [31:0] words [Cap];
  logic        live [Cap];
  int          used_cnt;
  int          dead_cnt;
  logic [31:0] id_ctr;
  answer_t     answer_q[$];

  assign pending_results = answer_q.size();
  assign used_now = used_cnt;
  assign next_id = id_ctr;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t mismatch %s: got %0h want %0h", $time, what, got, want);
    fail_count++;
  endtask

  // Drop dead slots once they make up half the used slots
  function automatic void compact_pool();
    int k;
    k = 0;
    if (dead_cnt < used_cnt / 2) return;
    for (int r = 0; r < used_cnt; r++) begin
      if (live[r]) begin
        tags[k] = tags[r];
        words[k] = words[r];
        k++;
      end
    end
    for (int r = 0; r < Cap; r++) live[r] = (r < k);
    used_cnt = k;
    dead_cnt = 0;
  endfunction

  function automatic answer_t apply_command(input cmd_t cmd, input logic [31:0] tid,
                                            input logic [6:0] fidx, input logic fst,
                                            input logic [31:0] wword);
    answer_t a;
    int start;
    a = '{ST_END, 7'(Cap), 32'd0, 32'd0};
    case (cmd)
      CMD_ALLOC: begin
        if (used_cnt >= Cap) begin
          a.status = ST_FULL;
        end else begin
          tags[used_cnt] = id_ctr;
          words[used_cnt] = wword;
          live[used_cnt] = 1'b1;
          a = '{ST_OK, 7'(used_cnt), id_ctr, 32'd0};
          used_cnt++;
          id_ctr++;
        end
      end
      CMD_FREE: begin
        a.status = ST_NOT_FOUND;
        for (int i = 0; i < used_cnt; i++) begin
          if (tags[i] == tid) begin
            live[i] = 1'b0;
            dead_cnt++;
            compact_pool();
            a.status = ST_OK;
            break;
          end
        end
      end
      CMD_ITER: begin
        start = int'(fidx) + (fst ? 0 : 1);
        for (int i = start; i < used_cnt; i++) begin
          if (live[i]) begin
            a = '{ST_OK, 7'(i), tags[i], words[i]};
            break;
          end
        end
      end
      default: ;
    endcase
    return a;
  endfunction

  // Predict on request beats, compare on response beats
  always @(posedge clk) begin
    answer_t want;
    if (rst) begin
      used_cnt <= 0;
      dead_cnt <= 0;
      id_ctr <= '0;
      fail_count <= 0;
      for (int i = 0; i < Cap; i++) live[i] = 1'b0;
      answer_q.delete();
    end else begin
      if (req_valid && req_ready)
        answer_q.push_back(apply_command(cmd_t'(req_cmd), req_target_id,
                                         req_from_index, req_from_start,
                                         req_write_word));
      if (rsp_valid && rsp_ready) begin
        if (answer_q.size() == 0) begin
          report_mismatch("unexpected beat", {30'd0, rsp_status}, 32'd0);
        end else begin
          want = answer_q.pop_front();
          if (rsp_status != want.status)
            report_mismatch("status", {30'd0, rsp_status}, {30'd0, want.status});
          if (rsp_slot_index != want.slot_index)
            report_mismatch("slot_index", {25'd0, rsp_slot_index}, {25'd0, want.slot_index});
          if (rsp_slot_id != want.slot_id)
            report_mismatch("slot_id", rsp_slot_id, want.slot_id);
          if (rsp_read_word != want.read_word)
            report_mismatch("read_word", rsp_read_word, want.read_word);
        end
      end
    end
  end

endmodule

// ===== dv/tb_id_tagged_slot_pool.sv =====
module tb_id_tagged_slot_pool;
  import itsp_pkg::*;

  localparam int IdleLimit = 20000;

  logic clk;
  logic rst;
  int   fail_count;
  int   pending_results;
  int   used_now;
  logic [31:0] next_id;
  logic quiet_phase;
  logic hold_rsp;
  int   sent;
  int   idle_cycles;
  int   alloc_cnt, free_cnt, iter_cnt;

  itsp_req_if req ();
  itsp_rsp_if rsp ();

  id_tagged_slot_pool u_top (
    .clk (clk),
    .rst (rst),
    .req (req.sink),
    .rsp (rsp.source)
  );

  tb_pool_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .req_cmd        (req.cmd),
    .req_target_id  (req.target_id),
    .req_from_index (req.from_index),
    .req_from_start (req.from_start),
    .req_write_word (req.write_word),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_status     (rsp.status),
    .rsp_slot_index (rsp.slot_index),
    .rsp_slot_id    (rsp.slot_id),
    .rsp_read_word  (rsp.read_word),
    .fail_count     (fail_count),
    .pending_results(pending_results),
    .used_now       (used_now),
    .next_id        (next_id)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Send one beat; optionally idle a random burst first
  task automatic send_beat(input cmd_t cmd, input logic [31:0] tid,
                           input logic [6:0] fidx, input logic fst,
                           input logic [31:0] wword);
    if (!quiet_phase && $urandom_range(0, 3) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    req.valid <= 1'b1;
    req.cmd <= cmd;
    req.target_id <= tid;
    req.from_index <= fidx;
    req.from_start <= fst;
    req.write_word <= wword;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    @(negedge clk);
    sent++;
    case (cmd)
      CMD_ALLOC: alloc_cnt++;
      CMD_FREE:  free_cnt++;
      CMD_ITER:  iter_cnt++;
      default: ;
    endcase
  endtask

  // Free ids mostly from the recent live window
  function automatic logic [31:0] pick_id();
    int span;
    span = (used_now > 0) ? used_now * 2 : 4;
    if ($urandom_range(0, 9) == 0) return $urandom();
    return next_id - 32'($urandom_range(1, span));
  endfunction

  // Stall the response side in random bursts
  initial begin
    hold_rsp = 1'b0;
    rsp.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (!quiet_phase && !hold_rsp && $urandom_range(0, 3) == 0) begin
        rsp.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(negedge clk);
      end else begin
        rsp.ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
    end
  end

  // Count cycles with no beat in either direction
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("timeout after %0d idle cycles", idle_cycles);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    int roll;
    quiet_phase = 1'b0;
    sent = 0;
    alloc_cnt = 0;
    free_cnt = 0;
    iter_cnt = 0;
    req.valid = 1'b0;
    req.cmd = CMD_NONE;
    req.target_id = '0;
    req.from_index = '0;
    req.from_start = 1'b0;
    req.write_word = '0;
    rst = 1'b1;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty pool, edge words, full table, frees, unknown command
    send_beat(CMD_ITER, '0, 7'd0, 1'b1, '0);
    send_beat(CMD_FREE, 32'd0, '0, 1'b0, '0);
    send_beat(CMD_NONE, 32'hFFFF_FFFF, 7'h7F, 1'b1, 32'hFFFF_FFFF);
    send_beat(CMD_ALLOC, '0, '0, 1'b0, 32'h0);
    send_beat(CMD_ALLOC, '1, '1, 1'b1, 32'hFFFF_FFFF);
    for (int i = 2; i < 66; i++)
      send_beat(CMD_ALLOC, '0, '0, 1'b0, $urandom());
    send_beat(CMD_ITER, '0, 7'd63, 1'b1, '0);
    send_beat(CMD_ITER, '0, 7'd63, 1'b0, '0);
    send_beat(CMD_ITER, '0, 7'd64, 1'b1, '0);
    send_beat(CMD_ITER, '0, 7'h7F, 1'b1, '0);
    send_beat(CMD_FREE, 32'd5, '0, 1'b0, '0);
    send_beat(CMD_FREE, 32'd5, '0, 1'b0, '0);
    send_beat(CMD_ITER, '0, 7'd4, 1'b0, '0);
    send_beat(CMD_FREE, 32'hFFFF_FFFF, '0, 1'b0, '0);
    for (int i = 0; i < 40; i += 2)
      send_beat(CMD_FREE, 32'(i), '0, 1'b0, '0);
    send_beat(CMD_ITER, '0, 7'd0, 1'b1, '0);
    req.valid <= 1'b0;

    // Let every answer drain before going on
    hold_rsp = 1'b1;
    while (pending_results != 0) @(negedge clk);
    hold_rsp = 1'b0;

    // Random mix weighted to keep the pool busy and compacting
    for (int n = 0; n < 1750; n++) begin
      if (n == 1500) quiet_phase = 1'b1;
      roll = $urandom_range(0, 99);
      if (roll < 40)
        send_beat(CMD_ALLOC, $urandom(), 7'($urandom()), 1'($urandom()), $urandom());
      else if (roll < 70)
        send_beat(CMD_FREE, pick_id(), 7'($urandom()), 1'($urandom()), $urandom());
      else if (roll < 97)
        send_beat(CMD_ITER, $urandom(), 7'($urandom_range(0, 70)), 1'($urandom()),
                  $urandom());
      else
        send_beat(CMD_NONE, $urandom(), 7'($urandom()), 1'($urandom()), $urandom());
    end
    req.valid <= 1'b0;

    while (pending_results != 0) @(negedge clk);
    repeat (3 * CapacityDef + 8) @(negedge clk);
    $display("sent %0d commands: %0d allocate, %0d free, %0d iterate",
             sent, alloc_cnt, free_cnt, iter_cnt);
    $display("covered full table, double free, compaction and end-of-pool walks");
    if (fail_count == 0 && pending_results == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
